>>> design/lis_length_via_lcs_defines.svh
// Assertion macros for the LIS length block.
// Included by design/lis_length_via_lcs.sv; no other dependencies.
`ifndef LIS_LENGTH_VIA_LCS_DEFINES_SVH
`define LIS_LENGTH_VIA_LCS_DEFINES_SVH
`ifndef SYNTH
`define LISLCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lislcs check failed");
`define LISLCS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("lislcs check failed");
`else
`define LISLCS_ASSERT(lbl, clk, rst, prop)
`define LISLCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> design/lislcs_pkg.sv
// Shared types and constants for the LIS length block.
// No dependencies.
`default_nettype none
package lislcs_pkg;
   localparam int MAX_LEN_DEF    = 1024;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int LEN_W          = 11;
   localparam int LEN_SAT        = 2047;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] lis_length;
      logic             overflow;
   } rsp_type;

   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_FETCH  = 7'b0000010,
      S_GRAB   = 7'b0000100,
      S_SEARCH = 7'b0001000,
      S_CMP    = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

>>> design/lis_length_via_lcs.sv
// Top level of the LIS length block: load sequencer and binary-search engine.
// Depends on lislcs_pkg, lislcs_ram and lis_length_via_lcs_defines.svh.
//
// Usage: drive req_data and raise start; a word is taken on a clock edge where
// start is high and busy is low. While loading, busy stays low and one word
// is taken per cycle. Words past MAX_LEN are dropped and flag overflow.
// The word with last set closes the sequence; busy then rises while the
// longest strictly increasing subsequence length is found by patience
// sorting: each stored element is placed by a binary search over a tail
// memory, each probe passing SEARCH then CMP through the single RAM read port.
// The result appears on rsp_data with rsp_valid high for exactly one cycle;
// the receiver cannot stall, and busy is already low in that cycle.
// Reset (synchronous, active high) empties the sequence and clears overflow;
// memory contents are not cleared and are never read before being written.
`default_nettype none
`include "lis_length_via_lcs_defines.svh"
module lis_length_via_lcs
   import lislcs_pkg::*;
#(
   parameter int MAX_LEN    = MAX_LEN_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic                ovf_ff, ovf_in;
   logic                rvalid_ff, rvalid_in;
   rsp_type             rdata_ff, rdata_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;

   logic [63:0]           wide_val;
   logic [DATA_WIDTH-1:0] key;
   logic                  accept, full;
   logic [CW:0]           mid_sum;
   logic [AW-1:0]         mid;
   logic [DATA_WIDTH-1:0] seq_rdata, tail_rdata;
   logic                  tail_we;
   logic [AW-1:0]         tail_raddr;
   logic [31:0]           len_wide;

   assign wide_val = {32'b0, req_data.value};
   assign key      = wide_val[DATA_WIDTH-1:0] ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};
   assign busy     = (state_ff != S_LOAD);
   assign accept   = start && !busy;
   assign full     = (count_ff == CW'(MAX_LEN));
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[AW:1];
   assign tail_we  = (state_ff == S_WRITE);
   assign tail_raddr = mid;
   assign len_wide = 32'(len_ff);

   lislcs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LEN)) u_seq_ram (
      .clock (clock),
      .we    (accept && !full),
      .waddr (count_ff[AW-1:0]),
      .wdata (key),
      .raddr (idx_ff[AW-1:0]),
      .rdata (seq_rdata)
   );

   lislcs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LEN)) u_tail_ram (
      .clock (clock),
      .we    (tail_we),
      .waddr (lo_ff[AW-1:0]),
      .wdata (x_ff),
      .raddr (tail_raddr),
      .rdata (tail_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ovf_in    = ovf_ff;
      x_in      = x_ff;
      rvalid_in = 1'b0;
      rdata_in  = rdata_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last) begin
                  idx_in   = '0;
                  len_in   = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_GRAB;
         end
         S_GRAB: begin
            x_in     = seq_rdata;
            lo_in    = '0;
            hi_in    = len_ff;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? S_CMP : S_WRITE;
         end
         S_CMP: begin
            if (tail_rdata >= x_ff) begin
               hi_in = CW'(mid);
            end else begin
               lo_in = CW'(mid) + CW'(1);
            end
            state_in = S_SEARCH;
         end
         S_WRITE: begin
            if (lo_ff == len_ff) begin
               len_in = len_ff + CW'(1);
            end
            idx_in   = idx_ff + CW'(1);
            state_in = (idx_ff + CW'(1) == count_ff) ? S_DONE : S_FETCH;
         end
         S_DONE: begin
            rvalid_in           = 1'b1;
            rdata_in.lis_length = (len_wide > 32'(LEN_SAT)) ? LEN_W'(LEN_SAT)
                                                            : len_wide[LEN_W-1:0];
            rdata_in.overflow   = ovf_ff;
            count_in            = '0;
            ovf_in              = 1'b0;
            state_in            = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         lo_ff     <= '0;
         hi_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rvalid_ff <= rvalid_in;
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
      end
      x_ff     <= x_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rdata_ff;

   `LISLCS_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid)
   `LISLCS_ASSERT(a_len_bound, clock, reset, (len_ff <= count_ff) || (state_ff == S_LOAD))
   `LISLCS_ASSERT(a_search_range, clock, reset, (lo_ff <= hi_ff) || (state_ff == S_LOAD))
   `LISLCS_ASSERT(a_done_then_idle, clock, reset, (state_ff == S_DONE) |=> !busy && rsp_valid)
   `LISLCS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid)
endmodule
`default_nettype wire

>>> design/lislcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lislcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
